/* design/mva_pkg.sv */
// mva_pkg: shared types and constants for the MIDI voice allocator.
// Used by mva_parser and midi_voice_allocator_unit; no dependencies.
`default_nettype none

package mva_pkg;

    // Default voice count and field widths
    localparam int NUM_VOICES_DEF = 9;
    localparam int VOICE_W        = 4;
    localparam int OCT_W          = 4;
    localparam int SEMI_W         = 4;
    localparam int SEL_W          = 3;
    localparam int DATA7_W        = 7;
    localparam int OUT_DATA_W     = 24;

    // Note handling constants
    localparam logic [7:0] NO_NOTE   = 8'hFF;
    localparam logic [6:0] LOW_NOTE  = 7'd24;
    localparam logic [6:0] HIGH_NOTE = 7'd119;
    localparam logic [6:0] OCT_SPAN  = 7'd12;
    localparam logic [6:0] CTL_MAX   = 7'd5;

    // MIDI byte codes
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [3:0] SYS_NIBBLE  = 4'hF;

    // Running status types (status nibble minus 8)
    localparam logic [2:0] TYPE_NOTE_OFF = 3'd0;
    localparam logic [2:0] TYPE_NOTE_ON  = 3'd1;
    localparam logic [2:0] TYPE_CONTROL  = 3'd3;
    localparam logic [2:0] TYPE_PROGRAM  = 3'd4;
    localparam logic [2:0] TYPE_CH_PRESS = 3'd5;

    // Result actions
    typedef enum logic [1:0] {
        ACT_KEY_ON  = 2'd0,
        ACT_KEY_OFF = 2'd1,
        ACT_SILENCE = 2'd2,
        ACT_SET_PAR = 2'd3
    } action_t;

    // Decoded message handed from parser to sequencer
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CONTROL = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [DATA7_W-1:0]   d0;
        logic [DATA7_W-1:0]   d1;
    } mva_cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_KEY_ON,
        ST_MATCH,
        ST_RELEASE,
        ST_SILENCE,
        ST_PARAM
    } seq_state_t;

endpackage

`default_nettype wire

/* design/midi_voice_allocator_unit.sv */
// midi_voice_allocator_unit: top level, MIDI byte in, voice actions out.
// Depends on mva_pkg and mva_parser.
//
//  Channel  Dir  Width  Contents
//  s_axis   in   8      tdata: midi_byte[7:0]
//  m_axis   out  24+1   tdata: action, voice, octave, semitone, param_select,
//                       param_value; tlast: last result of the byte
//
// One byte is taken per transaction; s_tready stays low until all of its
// results are loaded into the output register. A key-on takes one
// subtract-12 step per octave in the shared subtractor; a release matches
// the voice table, then scans the voices if any match; a control change
// above controller five silences every voice, else it also sets the
// parameter on every voice (one result per cycle while m_tready is high).
// A low m_tready stretches each result step. Reset is synchronous; the
// voice table resets to no note at once, no clearing pass.
`default_nettype none

module midi_voice_allocator_unit
    import mva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] midi_byte
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] action, [5:2] voice, [9:6] octave, [13:10] semitone,
    // [16:14] param_select, [23:17] param_value
    output      logic [OUT_DATA_W-1:0] m_tdata,
    output      logic                  m_tlast
);

    localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam logic [VIW-1:0] IDX_LAST = VIW'(NUM_VOICES - 1);

    seq_state_t state_reg, state_next;

    logic               in_accept;
    mva_cmd_t           cmd;
    logic [DATA7_W-1:0] d0_reg, d0_next;
    logic [DATA7_W-1:0] d1_reg, d1_next;
    logic [VIW-1:0]     idx_reg, idx_next;
    logic [VIW-1:0]     next_voice_reg, next_voice_next;
    logic [NUM_VOICES-1:0] mask_reg, mask_next;
    logic [NUM_VOICES-1:0] match_vec;
    logic [NUM_VOICES-1:0] idx_onehot;
    logic [DATA7_W-1:0] rem_reg, rem_next;
    logic [OCT_W-1:0]   oct_reg, oct_next;
    logic [DATA7_W-1:0] clamped;
    logic               idx_end;
    logic [7:0]         voice_notes_reg [NUM_VOICES];

    logic               out_free;
    logic               emit;
    action_t            out_action;
    logic [VOICE_W-1:0] out_voice;
    logic [OCT_W-1:0]   out_oct;
    logic [SEMI_W-1:0]  out_semi;
    logic [SEL_W-1:0]   out_sel;
    logic [DATA7_W-1:0] out_val;
    logic               out_last;
    logic               note_wr;
    logic [VIW-1:0]     note_wr_idx;
    logic [7:0]         note_wr_data;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    // Running status parser
    mva_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .midi_byte (s_tdata),
        .cmd       (cmd)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_end   = (idx_reg == IDX_LAST);
    assign idx_onehot = NUM_VOICES'(1) << idx_reg;

    // Clamp note into the playable range
    always_comb begin
        clamped = cmd.d0;
        if (cmd.d0 < LOW_NOTE) begin
            clamped = LOW_NOTE;
        end else if (cmd.d0 > HIGH_NOTE) begin
            clamped = HIGH_NOTE;
        end
    end

    // Voices holding the note to release
    always_comb begin
        for (int i = 0; i < NUM_VOICES; i++) begin
            match_vec[i] = (voice_notes_reg[i] == {1'b0, d0_reg});
        end
    end

    // Sequencer outputs: result payload and voice table writes
    always_comb begin
        emit         = 1'b0;
        out_action   = ACT_KEY_ON;
        out_voice    = VOICE_W'(idx_reg);
        out_oct      = '0;
        out_semi     = '0;
        out_sel      = '0;
        out_val      = '0;
        out_last     = 1'b0;
        note_wr      = 1'b0;
        note_wr_idx  = idx_reg;
        note_wr_data = NO_NOTE;
        case (state_reg)
            ST_KEY_ON: begin
                emit         = out_free;
                out_action   = ACT_KEY_ON;
                out_voice    = VOICE_W'(next_voice_reg);
                out_oct      = oct_reg;
                out_semi     = SEMI_W'(rem_reg);
                out_last     = 1'b1;
                note_wr      = out_free;
                note_wr_idx  = next_voice_reg;
                note_wr_data = {1'b0, d0_reg};
            end
            ST_RELEASE: begin
                emit       = out_free && mask_reg[idx_reg];
                out_action = ACT_KEY_OFF;
                out_last   = ((mask_reg & ~idx_onehot) == '0);
                note_wr    = emit;
            end
            ST_SILENCE: begin
                emit       = out_free;
                out_action = ACT_SILENCE;
                out_last   = idx_end && (d0_reg > CTL_MAX);
                note_wr    = out_free;
            end
            ST_PARAM: begin
                emit       = out_free;
                out_action = ACT_SET_PAR;
                out_sel    = SEL_W'(d0_reg);
                out_val    = d1_reg;
                out_last   = idx_end;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (cmd.kind)
                        CMD_NOTE_ON: state_next = ST_DIV;
                        CMD_RELEASE: state_next = ST_MATCH;
                        CMD_CONTROL: state_next = ST_SILENCE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (rem_reg < OCT_SPAN) begin
                    state_next = ST_KEY_ON;
                end
            end
            ST_KEY_ON: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH: begin
                state_next = (match_vec == '0) ? ST_IDLE : ST_RELEASE;
            end
            ST_RELEASE: begin
                if (emit && out_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SILENCE: begin
                if (emit && idx_end) begin
                    state_next = (d0_reg > CTL_MAX) ? ST_IDLE : ST_PARAM;
                end
            end
            ST_PARAM: begin
                if (emit && idx_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath next values; the subtractor is shared across octave steps
    always_comb begin
        d0_next         = d0_reg;
        d1_next         = d1_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        rem_next        = rem_reg;
        oct_next        = oct_reg;
        next_voice_next = next_voice_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (in_accept) begin
                    d0_next  = cmd.d0;
                    d1_next  = cmd.d1;
                    rem_next = clamped - LOW_NOTE;
                    oct_next = OCT_W'(1);
                end
            end
            ST_DIV: begin
                if (rem_reg >= OCT_SPAN) begin
                    rem_next = rem_reg - OCT_SPAN;
                    oct_next = oct_reg + 1'b1;
                end
            end
            ST_KEY_ON: begin
                if (emit) begin
                    next_voice_next = (next_voice_reg == IDX_LAST) ? '0
                                                                   : next_voice_reg + 1'b1;
                end
            end
            ST_MATCH: begin
                mask_next = match_vec;
                idx_next  = '0;
            end
            ST_RELEASE: begin
                if (emit) begin
                    mask_next = mask_reg & ~idx_onehot;
                end
                if (emit || !mask_reg[idx_reg]) begin
                    idx_next = idx_end ? '0 : idx_reg + 1'b1;
                end
            end
            ST_SILENCE, ST_PARAM: begin
                if (emit) begin
                    idx_next = idx_end ? '0 : idx_reg + 1'b1;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            next_voice_reg <= '0;
            mask_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            next_voice_reg <= next_voice_next;
            mask_reg       <= mask_next;
        end
    end

    // Working payload registers
    always_ff @(posedge aclk) begin
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
        rem_reg <= rem_next;
        oct_reg <= oct_next;
    end

    // Voice note table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                voice_notes_reg[i] <= NO_NOTE;
            end
        end else if (note_wr) begin
            voice_notes_reg[note_wr_idx] <= note_wr_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {out_val, out_sel, out_semi, out_oct, out_voice, out_action};
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A result is only loaded when the output slot is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending transaction");

    // Round robin pointer stays inside the voice range
    a_voice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_voice_reg <= IDX_LAST)
        else $error("next voice out of range");

    // A release scan always has a voice left to release
    a_scan_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RELEASE |-> mask_reg != '0)
        else $error("release scan with empty match set");

    // Octave never exceeds eight during division
    a_oct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_KEY_ON) |-> oct_reg <= OCT_W'(8))
        else $error("octave out of range");

    // The input side stays closed while a message is being played out
    a_busy_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && cmd.kind != CMD_NONE) |=> !s_tready)
        else $error("input accepted while sequencer busy");

endmodule

`default_nettype wire

/* design/mva_parser.sv */
// mva_parser: MIDI running status tracker, turns bytes into decoded messages.
// Depends on mva_pkg.
`default_nettype none

module mva_parser
    import mva_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [7:0] midi_byte,
    output mva_cmd_t        cmd
);

    logic [2:0]         running_type_reg, running_type_next;
    logic [1:0]         msg_len_reg, msg_len_next;
    logic               collected_reg, collected_next;
    logic [DATA7_W-1:0] first_data_reg, first_data_next;

    // Decode the byte against the running status
    always_comb begin
        running_type_next = running_type_reg;
        msg_len_next      = msg_len_reg;
        collected_next    = collected_reg;
        first_data_next   = first_data_reg;
        cmd.kind          = CMD_NONE;
        cmd.d0            = '0;
        cmd.d1            = '0;
        if (midi_byte[7] && midi_byte != SYSEX_END) begin
            // channel status sets a new running status, system bytes drop out
            if (midi_byte[7:4] != SYS_NIBBLE) begin
                running_type_next = midi_byte[6:4];
                collected_next    = 1'b0;
                msg_len_next      = (midi_byte[6:4] == TYPE_PROGRAM ||
                                     midi_byte[6:4] == TYPE_CH_PRESS) ? 2'd1 : 2'd2;
            end
        end else if (msg_len_reg != 2'd0) begin
            if (msg_len_reg == 2'd2 && !collected_reg) begin
                first_data_next = midi_byte[6:0];
                collected_next  = 1'b1;
            end else begin
                if (msg_len_reg == 2'd2) begin
                    cmd.d0 = first_data_reg;
                    cmd.d1 = midi_byte[6:0];
                end else begin
                    cmd.d0 = midi_byte[6:0];
                end
                collected_next  = 1'b0;
                first_data_next = '0;
                case (running_type_reg)
                    TYPE_NOTE_OFF: cmd.kind = CMD_RELEASE;
                    TYPE_NOTE_ON:  cmd.kind = (cmd.d1 == '0) ? CMD_RELEASE : CMD_NOTE_ON;
                    TYPE_CONTROL:  cmd.kind = CMD_CONTROL;
                    default:       cmd.kind = CMD_NONE;
                endcase
            end
        end
    end

    // Status registers update only on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_type_reg <= '0;
            msg_len_reg      <= '0;
            collected_reg    <= 1'b0;
            first_data_reg   <= '0;
        end else if (in_accept) begin
            running_type_reg <= running_type_next;
            msg_len_reg      <= msg_len_next;
            collected_reg    <= collected_next;
            first_data_reg   <= first_data_next;
        end
    end

    // A pending first data byte only exists for two-byte messages
    a_collect_len: assert property (@(posedge aclk) disable iff (!aresetn)
        collected_reg |-> msg_len_reg == 2'd2)
        else $error("first data byte held for a one-byte message");

    // A decoded message never appears without a length set
    a_cmd_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.kind != CMD_NONE |-> msg_len_reg != 2'd0)
        else $error("message decoded with no running status");

    // Second-byte completion clears the pending byte
    a_collect_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && collected_reg && !midi_byte[7]) |=> !collected_reg)
        else $error("pending data byte not cleared");

endmodule

`default_nettype wire

/* test/tb_midi_voice_allocator_unit.sv */
// tb_midi_voice_allocator_unit: self-checking bench for the MIDI voice allocator.
// Needs mva_pkg and midi_voice_allocator_unit; feeds MIDI bytes, predicts voice
// actions in-bench and checks every output transaction against the prediction.

module tb_midi_voice_allocator_unit;
    import mva_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 125;
    localparam int SETTLE_CYCLES = 60;

    // Channel status bytes (channel nibble zero) and system bytes
    localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
    localparam logic [7:0] MSG_KEY_PRESS = 8'hA0;
    localparam logic [7:0] MSG_CONTROL   = 8'hB0;
    localparam logic [7:0] MSG_PROGRAM   = 8'hC0;
    localparam logic [7:0] MSG_CH_PRESS  = 8'hD0;
    localparam logic [7:0] MSG_PITCH     = 8'hE0;
    localparam logic [7:0] SYS_CLOCK     = 8'hF8;
    localparam logic [7:0] SYS_SENSE     = 8'hFE;

    typedef struct packed {
        action_t    act;
        logic [3:0] voice;
        logic [3:0] octave;
        logic [3:0] semitone;
        logic [2:0] sel;
        logic [6:0] value;
        logic       last;
    } voice_action_t;

    // One queued byte, or a marker that holds the sender until all results are in
    typedef struct packed {
        logic       drain;
        logic [7:0] midi;
    } midi_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic        m_tlast;

    midi_item_t    midi_feed[$];
    voice_action_t pending_actions[$];
    voice_action_t byte_actions[$];

    int bytes_sent     = 0;
    int bytes_taken    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int src_gap        = 0;
    int sink_gap       = 0;
    int fed_count      = 0;
    logic calm         = 1'b0;
    logic [2:0] gen_type = TYPE_NOTE_ON;

    // Predictor state: running status parser and voice table
    logic [2:0] run_type   = 3'd0;
    logic [1:0] msg_len    = 2'd0;
    logic       have_first = 1'b0;
    logic [6:0] first_data = 7'd0;
    logic [7:0] voice_notes[NUM_VOICES_DEF];
    int         next_voice = 0;

    midi_voice_allocator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void add_action(action_t a, int v, int oct, int semi, int sel,
                                       int val);
        voice_action_t r;
        r.act      = a;
        r.voice    = 4'(v);
        r.octave   = 4'(oct);
        r.semitone = 4'(semi);
        r.sel      = 3'(sel);
        r.value    = 7'(val);
        r.last     = 1'b0;
        byte_actions.push_back(r);
    endfunction

    // Work out the voice actions one MIDI byte causes and queue them
    task automatic track_midi_byte(input logic [7:0] b);
        logic [6:0] d0;
        logic [6:0] d1;
        voice_action_t r;
        int n;
        byte_actions.delete();
        if (b[7] && b != SYSEX_END) begin
            // system bytes leave running status alone
            if (b[7:4] != SYS_NIBBLE) begin
                run_type   = b[6:4];
                have_first = 1'b0;
                msg_len    = (run_type == TYPE_PROGRAM || run_type == TYPE_CH_PRESS) ?
                             2'd1 : 2'd2;
            end
        end else if (msg_len != 2'd0) begin
            if (msg_len == 2'd2 && !have_first) begin
                first_data = b[6:0];
                have_first = 1'b1;
            end else begin
                if (msg_len == 2'd2) begin
                    d0 = first_data;
                    d1 = b[6:0];
                end else begin
                    d0 = b[6:0];
                    d1 = 7'd0;
                end
                have_first = 1'b0;
                first_data = 7'd0;
                if (run_type == TYPE_NOTE_OFF || run_type == TYPE_NOTE_ON) begin
                    if (run_type == TYPE_NOTE_OFF || d1 == 7'd0) begin
                        // release every voice holding the note
                        for (int i = 0; i < NUM_VOICES_DEF; i++) begin
                            if (voice_notes[i] == {1'b0, d0}) begin
                                voice_notes[i] = NO_NOTE;
                                add_action(ACT_KEY_OFF, i, 0, 0, 0, 0);
                            end
                        end
                    end else begin
                        // round robin key-on, note clamped for pitch only
                        voice_notes[next_voice] = {1'b0, d0};
                        n = int'(d0);
                        if (n < int'(LOW_NOTE)) n = int'(LOW_NOTE);
                        if (n > int'(HIGH_NOTE)) n = int'(HIGH_NOTE);
                        add_action(ACT_KEY_ON, next_voice, 1 + (n - int'(LOW_NOTE)) / 12,
                                   n % 12, 0, 0);
                        next_voice = (next_voice == NUM_VOICES_DEF - 1) ? 0 : next_voice + 1;
                    end
                end else if (run_type == TYPE_CONTROL) begin
                    for (int i = 0; i < NUM_VOICES_DEF; i++) begin
                        voice_notes[i] = NO_NOTE;
                        add_action(ACT_SILENCE, i, 0, 0, 0, 0);
                    end
                    if (d0 <= CTL_MAX) begin
                        for (int i = 0; i < NUM_VOICES_DEF; i++)
                            add_action(ACT_SET_PAR, i, 0, 0, int'(d0), int'(d1));
                    end
                end
            end
        end
        for (int i = 0; i < byte_actions.size(); i++) begin
            r = byte_actions[i];
            r.last = (i == byte_actions.size() - 1);
            pending_actions.push_back(r);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        midi_item_t it;
        it.drain = 1'b0;
        it.midi  = b;
        midi_feed.push_back(it);
        if (!(b[7:4] == SYS_NIBBLE && b != SYSEX_END))
            fed_count++;
    endtask

    task automatic queue_drain();
        midi_item_t it;
        it.drain = 1'b1;
        it.midi  = 8'h00;
        midi_feed.push_back(it);
    endtask

    // Mostly well-formed messages aimed at a small note pool, plus noise
    task automatic queue_random_message();
        int pick;
        int t;
        logic [2:0] kind;
        logic [3:0] chan;
        logic [6:0] d0;
        logic [6:0] d1;
        logic [7:0] junk;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            junk = 8'($urandom_range(0, 255));
            queue_byte(junk);
        end else if (pick < 10) begin
            junk = {SYS_NIBBLE, 4'($urandom_range(0, 15))};
            queue_byte(junk);
        end else begin
            t = $urandom_range(0, 99);
            if (t < 45)
                kind = TYPE_NOTE_ON;
            else if (t < 60)
                kind = TYPE_NOTE_OFF;
            else if (t < 70)
                kind = TYPE_CONTROL;
            else
                kind = 3'($urandom_range(2, 6));
            chan = 4'($urandom_range(0, 15));
            // sometimes lean on running status
            if (kind != gen_type || $urandom_range(0, 2) == 0)
                queue_byte({1'b1, kind, chan});
            gen_type = kind;
            if (kind == TYPE_NOTE_ON || kind == TYPE_NOTE_OFF) begin
                if ($urandom_range(0, 9) < 7)
                    d0 = 7'($urandom_range(36, 43));
                else
                    d0 = 7'($urandom_range(0, 127));
                if ($urandom_range(0, 9) < 3)
                    d1 = 7'd0;
                else
                    d1 = 7'($urandom_range(1, 127));
            end else if (kind == TYPE_CONTROL) begin
                if ($urandom_range(0, 3) != 0)
                    d0 = 7'($urandom_range(0, 7));
                else
                    d0 = 7'($urandom_range(0, 127));
                d1 = 7'($urandom_range(0, 127));
            end else begin
                d0 = 7'($urandom_range(0, 127));
                d1 = 7'($urandom_range(0, 127));
            end
            queue_byte({1'b0, d0});
            if ($urandom_range(0, 19) == 0)
                queue_byte(SYS_CLOCK);
            // occasionally cut the message short
            if (!(kind == TYPE_PROGRAM || kind == TYPE_CH_PRESS) && $urandom_range(0, 19) != 0)
                queue_byte({1'b0, d1});
        end
    endtask

    task automatic report_mismatch(input string what, input voice_action_t want,
                                   input voice_action_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"cycle %0d %s: expected act=%0d voice=%0d oct=%0d semi=%0d ",
                      "sel=%0d val=%0d last=%0d, got act=%0d voice=%0d oct=%0d ",
                      "semi=%0d sel=%0d val=%0d last=%0d"},
                     cycle_count, what, want.act, want.voice, want.octave, want.semitone,
                     want.sel, want.value, want.last, got.act, got.voice, got.octave,
                     got.semitone, got.sel, got.value, got.last);
    endtask

    // Sender: one byte per transaction, predicted as soon as it is presented
    always @(negedge aclk) begin
        midi_item_t it;
        calm <= (midi_feed.size() < 25);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || bytes_taken == bytes_sent) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap--;
            end else if (midi_feed.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (midi_feed[0].drain) begin
                s_tvalid <= 1'b0;
                if (pending_actions.size() == 0)
                    it = midi_feed.pop_front();
            end else if (!calm && (cycle_count % 1024) < 768 && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                src_gap = $urandom_range(1, 14) - 1;
            end else begin
                it = midi_feed.pop_front();
                s_tdata  <= it.midi;
                s_tvalid <= 1'b1;
                bytes_sent++;
                track_midi_byte(it.midi);
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap--;
        end else if (!calm && (cycle_count % 1024) < 768 && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_gap = $urandom_range(1, 14) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: count input transactions, check each result transaction
    always @(posedge aclk) begin
        voice_action_t got;
        voice_action_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                bytes_taken++;
            if (m_tvalid && m_tready) begin
                got.act      = action_t'(m_tdata[1:0]);
                got.voice    = m_tdata[5:2];
                got.octave   = m_tdata[9:6];
                got.semitone = m_tdata[13:10];
                got.sel      = m_tdata[16:14];
                got.value    = m_tdata[23:17];
                got.last     = m_tlast;
                if (pending_actions.size() == 0) begin
                    want = '0;
                    report_mismatch("result with nothing expected", want, got);
                end else begin
                    want = pending_actions.pop_front();
                    if (got.act !== want.act || got.voice !== want.voice ||
                        got.octave !== want.octave || got.semitone !== want.semitone ||
                        got.sel !== want.sel || got.value !== want.value ||
                        got.last !== want.last)
                        report_mismatch("field mismatch", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** midi_voice_allocator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_VOICES_DEF; i++)
            voice_notes[i] = NO_NOTE;

        // Directed: data before status and system bytes are ignored
        queue_byte(8'h45);
        queue_byte(SYS_SENSE);
        // key-on, then clamp at both ends of the note range
        queue_byte(MSG_NOTE_ON);
        queue_byte(8'h3C); queue_byte(8'h64);
        queue_byte(8'h00); queue_byte(8'h7F);
        queue_byte(8'h7F); queue_byte(8'h01);
        // zero velocity releases
        queue_byte(8'h3C); queue_byte(8'h00);
        // end of exclusive taken as data, once as velocity and once as note
        queue_byte(8'h3C); queue_byte(SYSEX_END);
        queue_byte(SYSEX_END); queue_byte(8'h40);
        // realtime byte inside a message, second voice on the same note
        queue_byte(8'h3C); queue_byte(SYS_CLOCK); queue_byte(8'h50);
        // note-off with velocity releases both, then a release with no match
        queue_byte(MSG_NOTE_OFF | 8'h03);
        queue_byte(8'h3C); queue_byte(8'h40);
        queue_byte(8'h3C); queue_byte(8'h00);
        // control change with parameter write, then above the parameter range
        queue_byte(MSG_CONTROL);
        queue_byte(8'h00); queue_byte(8'h7F);
        queue_byte(8'h06); queue_byte(8'h40);
        // silent message types
        queue_byte(MSG_KEY_PRESS | 8'h0F); queue_byte(8'h10); queue_byte(8'h20);
        queue_byte(MSG_PROGRAM); queue_byte(8'h7F);
        queue_byte(MSG_CH_PRESS); queue_byte(8'h00);
        queue_byte(MSG_PITCH); queue_byte(8'h00); queue_byte(8'h7F);
        queue_drain();

        // Random part, with a full drain after each message near the halfway point
        fed_count = 0;
        while (fed_count < RANDOM_BYTES) begin
            queue_random_message();
            if (fed_count >= RANDOM_BYTES / 2 && fed_count < RANDOM_BYTES / 2 + 4)
                queue_drain();
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (midi_feed.size() != 0 || bytes_taken != bytes_sent ||
               pending_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (pending_actions.size() != 0)
            $display("%0d expected results never arrived", pending_actions.size());
        if (mismatch_count == 0 && pending_actions.size() == 0) begin
            $display("** midi_voice_allocator_unit: PASSED **");
        end else begin
            $display("** midi_voice_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
